/* hw/rtl/mcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types and constants for the minute calendar counter.
// ----------------------------------------------------------------------------
package mcc_pkg;

  // Operation codes carried in the func field
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // Year wraps to zero on reaching this value (range 4..128)
  localparam int YEAR_SPAN = 100;

  // Input word: one minute tick or one set command
  typedef struct packed {
    logic       func;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } req_word_t;

  // Result word: full date and time after the item
  typedef struct packed {
    logic [5:0] sec_now;
    logic [5:0] min_now;
    logic [4:0] hour_now;
    logic [4:0] day_now;
    logic [3:0] month_now;
    logic [6:0] year_now;
    logic [8:0] day_of_year;
    logic       leap_year;
    logic       date_event;
    logic       time_event;
  } rsp_word_t;

  // Calendar state
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [8:0] yday;
    logic       leap;
  } cal_state_t;

  // Reset: 00:00:00, first of January, year zero (leap)
  localparam cal_state_t CAL_RESET = '{
    sec:   6'd0,
    min:   6'd0,
    hour:  5'd0,
    day:   5'd1,
    month: 4'd1,
    year:  7'd0,
    yday:  9'd0,
    leap:  1'b1
  };

endpackage

/* hw/rtl/mcc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_step
// Next-state and result logic for one tick or set word.
// ----------------------------------------------------------------------------
module mcc_step (
  input  mcc_pkg::cal_state_t cur,
  input  mcc_pkg::req_word_t  word,
  output mcc_pkg::cal_state_t nxt,
  output mcc_pkg::rsp_word_t  result
);
  import mcc_pkg::*;

  localparam logic [5:0] MIN_WRAP   = 6'd60;
  localparam logic [4:0] HOUR_WRAP  = 5'd24;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_DEC  = 4'd12;
  localparam logic [3:0] MONTH_JAN  = 4'd1;
  localparam logic [3:0] LEN_MASK   = 4'b1001;
  localparam logic [7:0] YEAR_LIMIT = 8'(YEAR_SPAN);

  // Days before month m in a non-leap year; months 13..15 keep the length rule
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      4'd13:   d = 9'd365;
      4'd14:   d = 9'd395;
      4'd15:   d = 9'd426;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Bit rule: Feb by leap, else 30 when m[3]==m[0], 31 otherwise
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
    logic [3:0] sel;
    logic [4:0] len;
    sel = m & LEN_MASK;
    if (m == MONTH_FEB) begin
      len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
    end else if (sel == LEN_MASK || sel == 4'd0) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  logic [5:0] min_inc;
  logic [4:0] hour_inc;
  logic [7:0] year_inc;
  logic [6:0] year_wrap;
  logic       month_end;
  logic       set_leap;
  logic [8:0] set_off;
  logic       date_chg;

  assign min_inc   = cur.min + 6'd1;
  assign hour_inc  = cur.hour + 5'd1;
  assign year_inc  = {1'b0, cur.year} + 8'd1;
  assign year_wrap = (year_inc == YEAR_LIMIT) ? 7'd0 : year_inc[6:0];
  assign month_end = (cur.day == month_len(cur.month, cur.year));
  assign set_leap  = (word.year[1:0] == 2'b00);
  assign set_off   = cum_days(word.month)
                   + {8'd0, (set_leap && (word.month > MONTH_FEB))};

  always_comb begin
    nxt      = cur;
    date_chg = 1'b0;
    if (word.func == FUNC_SET) begin
      nxt.sec   = word.second;
      nxt.min   = word.minute;
      nxt.hour  = word.hour;
      nxt.day   = word.day;
      nxt.month = word.month;
      nxt.year  = word.year;
      nxt.leap  = set_leap;
      // zero-based: offset + day - 1, modulo 512
      nxt.yday  = set_off + {4'd0, word.day} + 9'h1FF;
      date_chg  = 1'b1;
    end else begin
      nxt.sec = word.second;
      nxt.min = min_inc;
      if (min_inc == MIN_WRAP) begin
        nxt.min  = 6'd0;
        nxt.hour = hour_inc;
        if (hour_inc == HOUR_WRAP) begin
          nxt.hour = 5'd0;
          date_chg = 1'b1;
          nxt.day  = cur.day + 5'd1;
          nxt.yday = cur.yday + 9'd1;
          if (month_end) begin
            nxt.day = 5'd1;
            if (cur.month == MONTH_DEC) begin
              nxt.year  = year_wrap;
              nxt.leap  = (year_wrap[1:0] == 2'b00);
              nxt.month = MONTH_JAN;
              nxt.yday  = 9'd0;
            end else begin
              nxt.month = cur.month + 4'd1;
            end
          end
        end
      end
    end
  end

  assign result.sec_now     = nxt.sec;
  assign result.min_now     = nxt.min;
  assign result.hour_now    = nxt.hour;
  assign result.day_now     = nxt.day;
  assign result.month_now   = nxt.month;
  assign result.year_now    = nxt.year;
  assign result.day_of_year = nxt.yday;
  assign result.leap_year   = nxt.leap;
  assign result.date_event  = date_chg;
  assign result.time_event  = 1'b1;

endmodule

/* hw/rtl/minute_calendar_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minute_calendar_counter
// Minute-driven calendar counter, two-digit year, with set command.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------
//  req     | in  | req_valid / req_stall | req_word_t: tick or set word
//  rsp     | out | rsp_valid / rsp_stall | rsp_word_t: date, time and flags
//
//  One word accepted per clock while req_stall is low. The word is captured
//  in the input register, the calendar logic runs between that register and
//  the result register, and the state updates on the same edge the result
//  is captured.
//  rst (synchronous, active high) clears the valids and sets the calendar
//  to 00:00:00, day 1, month 1, year 0, leap.
//  A stall on rsp holds the result register; the input register then holds
//  too and req_stall is raised only when that register is occupied.
// ----------------------------------------------------------------------------
module minute_calendar_counter (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  mcc_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output mcc_pkg::rsp_word_t rsp
);
  import mcc_pkg::*;

  // input register
  logic      s1_valid;
  req_word_t s1_word;

  // calendar state
  cal_state_t state;
  cal_state_t state_next;
  rsp_word_t  result;

  logic out_ready;   // result register can take a word
  logic advance;     // word moves from input register to result register
  logic accept;

  assign out_ready = !rsp_valid || !rsp_stall;
  assign advance   = s1_valid && out_ready;
  assign req_stall = s1_valid && !out_ready;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= req;
    end
  end

  mcc_step u_step (
    .cur    (state),
    .word   (s1_word),
    .nxt    (state_next),
    .result (result)
  );

  // State commits when the word's result is captured
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CAL_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  // Leap flag always tracks the stored year
  a_leap_tracks_year: assert property (@(posedge clk) disable iff (rst)
    state.leap == (state.year[1:0] == 2'b00))
    else $error("leap flag out of step with year");

  // Input side only backs up when the input register is full
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid)
    else $error("req stalled with empty input register");

  // A set word's year lands in the state as given
  a_set_loads_year: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_word.func == FUNC_SET) |=> (state.year == $past(s1_word.year)))
    else $error("set word did not load year");

  // Result day of year and minute match the state it committed
  a_rsp_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (rsp.day_of_year == state.yday && rsp.min_now == state.min))
    else $error("result differs from committed state");

  // Every result reports a time change
  a_time_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.time_event)
    else $error("time flag low on a result");

endmodule
